// ----- sv/spq_pkg.sv -----
package spq_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int INDEX_BITS_DEF = 10;

	localparam int CMD_W    = 2;
	localparam int THREAD_W = 10;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Shift control broadcast to every cell of the row.
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PRIO_W-1:0] new_prio;
	} cell_ctrl_t;

endpackage

// ----- sv/spq_req_if.sv -----
interface spq_req_if;
	import spq_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [THREAD_W-1:0] thread_index;
	logic [PRIO_W-1:0]   priority_req;

	modport source (output valid, output cmd, output thread_index, output priority_req,
		input ready);
	modport sink (input valid, input cmd, input thread_index, input priority_req,
		output ready);

endinterface

// ----- sv/spq_rsp_if.sv -----
interface spq_rsp_if;
	import spq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [THREAD_W-1:0] removed_index;
	logic [PRIO_W-1:0]   top_priority;
	logic                is_empty;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output status, output removed_index, output top_priority,
		output is_empty, output entry_count, input ready);
	modport sink (input valid, input status, input removed_index, input top_priority,
		input is_empty, input entry_count, output ready);

endinterface

// ----- sv/stable_priority_queue_core.sv -----
// The result of a request is captured in the output register when the request is accepted.
// Throughput: one request per cycle while the response side is ready; every cell of the row shifts in the same cycle,
// and a new request is taken in the cycle in which the previous result leaves the output register.
// Reset clears the entry count and the output valid; slot contents are not cleared,
// since only slots below the count are ever read. There is no clearing pass.
module stable_priority_queue_core #(
	parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
	parameter int INDEX_BITS = spq_pkg::INDEX_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_nxt;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [THREAD_W-1:0]   removed_q;
	logic [PRIO_W-1:0]     top_q;
	logic                  empty_q;
	logic [COUNT_W-1:0]    entry_count_q;

	logic                  accept;
	logic                  full;
	cell_ctrl_t            ctrl;
	status_t               status_nxt;
	logic [THREAD_W-1:0]   removed_nxt;
	logic [PRIO_W-1:0]     top_nxt;
	logic [INDEX_BITS-1:0] new_thread;

	logic [PRIO_W-1:0]     prio_w   [CAPACITY];
	logic [INDEX_BITS-1:0] thread_w [CAPACITY];
	logic                  ahead_w  [CAPACITY];

	assign req.ready  = !out_valid_q || rsp.ready;
	assign accept     = req.valid && req.ready;
	assign full       = count_q >= CW'(CAPACITY);
	assign new_thread = INDEX_BITS'(req.thread_index);

	always_comb begin
		ctrl.ins      = 1'b0;
		ctrl.rem      = 1'b0;
		ctrl.new_prio = req.priority_req;
		count_nxt     = count_q;
		status_nxt    = ST_DONE;
		removed_nxt   = '0;
		unique case (cmd_t'(req.cmd))
			CMD_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctrl.ins  = accept;
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					ctrl.rem    = accept;
					count_nxt   = count_q - CW'(1);
					removed_nxt = THREAD_W'(thread_w[0]);
				end
			end
			CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase

		// Priority that will sit in the head cell after this request.
		if (count_nxt == '0) begin
			top_nxt = '0;
		end else if (cmd_t'(req.cmd) == CMD_INSERT && !full && ahead_w[0]) begin
			top_nxt = req.priority_req;
		end else if (cmd_t'(req.cmd) == CMD_REMOVE) begin
			top_nxt = prio_w[1];
		end else begin
			top_nxt = prio_w[0];
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  bl;
		logic [PRIO_W-1:0]     lp;
		logic [INDEX_BITS-1:0] lt;
		logic [PRIO_W-1:0]     rp;
		logic [INDEX_BITS-1:0] rt;

		if (i == 0) begin : g_head
			assign bl = 1'b0;
			assign lp = '0;
			assign lt = '0;
		end else begin : g_mid
			assign bl = ahead_w[i-1];
			assign lp = prio_w[i-1];
			assign lt = thread_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rp = prio_w[i];
			assign rt = thread_w[i];
		end else begin : g_body
			assign rp = prio_w[i+1];
			assign rt = thread_w[i+1];
		end

		spq_cell #(
			.IDX (i),
			.CW  (CW),
			.TW  (INDEX_BITS)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.count        (count_q),
			.new_thread   (new_thread),
			.ahead_left   (bl),
			.left_prio    (lp),
			.left_thread  (lt),
			.right_prio   (rp),
			.right_thread (rt),
			.ahead        (ahead_w[i]),
			.prio         (prio_w[i]),
			.thread       (thread_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_nxt;
			removed_q     <= removed_nxt;
			top_q         <= top_nxt;
			empty_q       <= count_nxt == '0;
			entry_count_q <= COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_index = removed_q;
	assign rsp.top_priority  = top_q;
	assign rsp.is_empty      = empty_q;
	assign rsp.entry_count   = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_t'(req.cmd) == CMD_INSERT && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the queue");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (empty_q == (count_q == '0)))
		else $error("empty flag disagrees with entry count");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_DONE |-> removed_q == '0)
		else $error("removed index set on a failed request");

endmodule

// ----- sv/spq_cell.sv -----
module spq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6,
	parameter int TW  = 10
) (
	input  logic                      clk,
	input  spq_pkg::cell_ctrl_t       ctrl,
	input  logic [CW-1:0]             count,
	input  logic [TW-1:0]             new_thread,
	input  logic                      ahead_left,
	input  logic [spq_pkg::PRIO_W-1:0] left_prio,
	input  logic [TW-1:0]             left_thread,
	input  logic [spq_pkg::PRIO_W-1:0] right_prio,
	input  logic [TW-1:0]             right_thread,
	output logic                      ahead,
	output logic [spq_pkg::PRIO_W-1:0] prio,
	output logic [TW-1:0]             thread
);
	import spq_pkg::*;

	logic [PRIO_W-1:0] prio_q;
	logic [TW-1:0]     thread_q;
	logic              occupied;

	assign occupied = CW'(IDX) < count;

	// The new entry belongs ahead of this cell unless this cell holds an entry
	// of equal or higher priority.
	assign ahead  = !(occupied && (prio_q >= ctrl.new_prio));
	assign prio   = prio_q;
	assign thread = thread_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && ahead) begin
			if (ahead_left) begin
				prio_q   <= left_prio;
				thread_q <= left_thread;
			end else begin
				prio_q   <= ctrl.new_prio;
				thread_q <= new_thread;
			end
		end else if (ctrl.rem) begin
			prio_q   <= right_prio;
			thread_q <= right_thread;
		end
	end

endmodule
